[sv/mi4_pkg.sv]
package mi4_pkg;

   localparam int MATRIX_ELEMENTS = 16;
   localparam int IDX_W = 4;
   localparam int ELEM_W = 16;
   localparam int COF_W = 50;
   localparam int DET_W = 58;
   localparam int DSUM_W = 68;
   localparam int Q_W = 33;
   localparam int OUT_W = 32;
   localparam int THR_W = 32;
   localparam logic [THR_W-1:0] THRESHOLD_RESET = 32'd168;

   typedef struct packed {
      logic signed [ELEM_W-1:0] value;
      logic [IDX_W-1:0] idx;
   } elem_type;

   typedef struct packed {
      logic [IDX_W-1:0] a;
      logic [IDX_W-1:0] b;
      logic [IDX_W-1:0] c;
      logic neg;
   } term_type;

   // one signed triple product of the 3x3 minor behind adjugate entry k
   function automatic term_type cof_term(input logic [IDX_W-1:0] k, input logic [2:0] t);
      logic [1:0] rs [3];
      logic [1:0] cs [3];
      logic [1:0] r;
      logic [1:0] c;
      logic [1:0] p0;
      logic [1:0] p1;
      logic [1:0] p2;
      logic odd;
      logic [1:0] ki;
      logic [1:0] ji;
      term_type tt;
      r = k[3:2];
      c = k[1:0];
      ki = 2'd0;
      ji = 2'd0;
      for (int i = 0; i < 3; i++) begin
         rs[i] = 2'd0;
         cs[i] = 2'd0;
      end
      for (int i = 0; i < 4; i++) begin
         if (2'(i) != c) begin
            rs[ki] = 2'(i);
            ki++;
         end
         if (2'(i) != r) begin
            cs[ji] = 2'(i);
            ji++;
         end
      end
      case (t)
         3'd1: begin p0 = 2'd0; p1 = 2'd2; p2 = 2'd1; odd = 1'b1; end
         3'd2: begin p0 = 2'd1; p1 = 2'd0; p2 = 2'd2; odd = 1'b1; end
         3'd3: begin p0 = 2'd1; p1 = 2'd2; p2 = 2'd0; odd = 1'b0; end
         3'd4: begin p0 = 2'd2; p1 = 2'd0; p2 = 2'd1; odd = 1'b0; end
         3'd5: begin p0 = 2'd2; p1 = 2'd1; p2 = 2'd0; odd = 1'b1; end
         default: begin p0 = 2'd0; p1 = 2'd1; p2 = 2'd2; odd = 1'b0; end
      endcase
      tt.a = {rs[0], cs[p0]};
      tt.b = {rs[1], cs[p1]};
      tt.c = {rs[2], cs[p2]};
      tt.neg = odd ^ r[0] ^ c[0];
      return tt;
   endfunction

endpackage

[sv/mi4_fifo.sv]
module mi4_fifo
   import mi4_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  elem_type din,
   input  logic     pop,
   output elem_type dout,
   output logic     full,
   output logic     empty
);

   elem_type slot_ff [2];
   elem_type slot_in [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full = count_ff == 2'd2;
   assign empty = count_ff == 2'd0;
   assign dout = slot_ff[rd_ptr_ff];

   always_comb begin
      slot_in = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = din;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

[sv/mi4_front.sv]
module mi4_front
   import mi4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [ELEM_W-1:0] element_value,
   input  logic                     queue_full,
   output logic                     busy,
   output logic                     push,
   output elem_type                 entry
);

   logic [IDX_W-1:0] load_count_ff, load_count_in;

   assign busy = queue_full;
   assign push = start && !queue_full;
   assign entry.value = element_value;
   assign entry.idx = load_count_ff;
   assign load_count_in = push ? load_count_ff + 4'd1 : load_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
      end else begin
         load_count_ff <= load_count_in;
      end
   end

endmodule

[sv/mi4_back.sv]
module mi4_back
   import mi4_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  elem_type                entry,
   input  logic                    queue_empty,
   input  logic [THR_W-1:0]        threshold,
   output logic                    pop,
   output logic                    rsp_valid,
   output logic signed [OUT_W-1:0] rsp_inverse_value,
   output logic                    rsp_singular,
   output logic                    rsp_last_of_run
);

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_COF_A = 4'd1;
   localparam logic [3:0] ST_COF_B = 4'd2;
   localparam logic [3:0] ST_COF_C = 4'd3;
   localparam logic [3:0] ST_COF_W = 4'd4;
   localparam logic [3:0] ST_DET_M = 4'd5;
   localparam logic [3:0] ST_DET_A = 4'd6;
   localparam logic [3:0] ST_MAG   = 4'd7;
   localparam logic [3:0] ST_CMP   = 4'd8;
   localparam logic [3:0] ST_NORM  = 4'd9;
   localparam logic [3:0] ST_DIV   = 4'd10;
   localparam logic [3:0] ST_OUT_0 = 4'd11;
   localparam logic [3:0] ST_OUT_1 = 4'd12;
   localparam logic [3:0] ST_OUT_2 = 4'd13;
   localparam logic [3:0] ST_OUT_3 = 4'd14;
   localparam logic [3:0] ST_OUT_4 = 4'd15;

   logic [3:0] state_ff, state_in;
   logic signed [ELEM_W-1:0] mat_ff [MATRIX_ELEMENTS];
   logic signed [ELEM_W-1:0] mat_in [MATRIX_ELEMENTS];
   logic signed [COF_W-1:0] cof_ff [MATRIX_ELEMENTS];
   logic signed [COF_W-1:0] cof_in [MATRIX_ELEMENTS];
   logic [IDX_W-1:0] k_ff, k_in;
   logic [2:0] t_ff, t_in;
   logic signed [ELEM_W-1:0] x_ff, x_in;
   logic signed [31:0] p1_ff, p1_in;
   logic signed [47:0] p2_ff, p2_in;
   logic signed [COF_W-1:0] acc_ff, acc_in;
   logic signed [65:0] dp_ff, dp_in;
   logic signed [DSUM_W-1:0] dsum_ff, dsum_in;
   logic det_neg_ff, det_neg_in;
   logic [DET_W-1:0] dmag_ff, dmag_in;
   logic sing_ff, sing_in;
   logic [5:0] e_ff, e_in;
   logic [DET_W:0] rem_ff, rem_in;
   logic [Q_W-1:0] q_ff, q_in;
   logic [5:0] div_cnt_ff, div_cnt_in;
   logic [COF_W-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   logic [57:0] plo_ff, plo_in;
   logic [57:0] phi_ff, phi_in;
   logic [83:0] sum_ff, sum_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_value_ff, rsp_value_in;
   logic rsp_sing_ff, rsp_sing_in;
   logic rsp_last_ff, rsp_last_in;

   term_type tt;
   logic signed [COF_W-1:0] p2_ext;
   logic signed [COF_W-1:0] cof_sel;
   logic signed [DET_W-1:0] det_val;
   logic rem_ge;
   logic [DET_W:0] rem_sub;
   logic [83:0] shifted;
   logic [6:0] shamt;

   assign tt = cof_term(k_ff, t_ff);
   assign p2_ext = {{2{p2_ff[47]}}, p2_ff};
   assign cof_sel = cof_ff[k_ff];
   assign det_val = dsum_ff[65:8];
   assign rem_ge = rem_ff >= {1'b0, dmag_ff};
   assign rem_sub = rem_ge ? rem_ff - {1'b0, dmag_ff} : rem_ff;
   assign shamt = 7'(e_ff) + 7'd16;
   assign shifted = sum_ff >> shamt;
   assign pop = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in = state_ff;
      mat_in = mat_ff;
      cof_in = cof_ff;
      k_in = k_ff;
      t_in = t_ff;
      x_in = x_ff;
      p1_in = p1_ff;
      p2_in = p2_ff;
      acc_in = acc_ff;
      dp_in = dp_ff;
      dsum_in = dsum_ff;
      det_neg_in = det_neg_ff;
      dmag_in = dmag_ff;
      sing_in = sing_ff;
      e_in = e_ff;
      rem_in = rem_ff;
      q_in = q_ff;
      div_cnt_in = div_cnt_ff;
      mag_in = mag_ff;
      neg_in = neg_ff;
      plo_in = plo_ff;
      phi_in = phi_ff;
      sum_in = sum_ff;
      rsp_valid_in = 1'b0;
      rsp_value_in = rsp_value_ff;
      rsp_sing_in = rsp_sing_ff;
      rsp_last_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               mat_in[entry.idx] = entry.value;
               if (entry.idx == 4'(MATRIX_ELEMENTS - 1)) begin
                  k_in = '0;
                  t_in = '0;
                  acc_in = '0;
                  state_in = ST_COF_A;
               end
            end
         end
         ST_COF_A: begin
            x_in = mat_ff[tt.a];
            state_in = ST_COF_B;
         end
         ST_COF_B: begin
            p1_in = x_ff * mat_ff[tt.b];
            state_in = ST_COF_C;
         end
         ST_COF_C: begin
            p2_in = p1_ff * mat_ff[tt.c];
            state_in = ST_COF_W;
         end
         ST_COF_W: begin
            acc_in = tt.neg ? acc_ff - p2_ext : acc_ff + p2_ext;
            state_in = ST_COF_A;
            if (t_ff == 3'd5) begin
               cof_in[k_ff] = acc_in;
               acc_in = '0;
               t_in = '0;
               k_in = k_ff + 4'd1;
               if (k_ff == 4'(MATRIX_ELEMENTS - 1)) begin
                  dsum_in = '0;
                  state_in = ST_DET_M;
               end
            end else begin
               t_in = t_ff + 3'd1;
            end
         end
         ST_DET_M: begin
            dp_in = mat_ff[{2'b00, k_ff[1:0]}] * cof_ff[{k_ff[1:0], 2'b00}];
            state_in = ST_DET_A;
         end
         ST_DET_A: begin
            dsum_in = dsum_ff + {{2{dp_ff[65]}}, dp_ff};
            k_in = k_ff + 4'd1;
            state_in = (k_ff[1:0] == 2'd3) ? ST_MAG : ST_DET_M;
         end
         ST_MAG: begin
            det_neg_in = det_val[DET_W-1];
            dmag_in = det_val[DET_W-1] ? DET_W'(-det_val) : DET_W'(det_val);
            state_in = ST_CMP;
         end
         ST_CMP: begin
            sing_in = dmag_ff <= {26'd0, threshold};
            e_in = 6'(DET_W - 1);
            k_in = '0;
            state_in = sing_in ? ST_OUT_0 : ST_NORM;
         end
         ST_NORM: begin
            if (dmag_ff[DET_W-1]) begin
               rem_in = {2'b01, {(DET_W-1){1'b0}}};
               q_in = '0;
               div_cnt_in = 6'(Q_W - 1);
               state_in = ST_DIV;
            end else begin
               dmag_in = {dmag_ff[DET_W-2:0], 1'b0};
               e_in = e_ff - 6'd1;
            end
         end
         ST_DIV: begin
            q_in = {q_ff[Q_W-2:0], rem_ge};
            rem_in = {rem_sub[DET_W-1:0], 1'b0};
            div_cnt_in = div_cnt_ff - 6'd1;
            if (div_cnt_ff == 6'd0) begin
               state_in = ST_OUT_0;
            end
         end
         ST_OUT_0: begin
            neg_in = cof_sel[COF_W-1] ^ det_neg_ff;
            mag_in = cof_sel[COF_W-1] ? COF_W'(-cof_sel) : COF_W'(cof_sel);
            state_in = ST_OUT_1;
         end
         ST_OUT_1: begin
            plo_in = mag_ff[24:0] * q_ff;
            state_in = ST_OUT_2;
         end
         ST_OUT_2: begin
            phi_in = mag_ff[49:25] * q_ff;
            state_in = ST_OUT_3;
         end
         ST_OUT_3: begin
            sum_in = {26'd0, plo_ff} + {1'b0, phi_ff, 25'd0} + (84'd1 << (7'(e_ff) + 7'd15));
            state_in = ST_OUT_4;
         end
         ST_OUT_4: begin
            rsp_valid_in = 1'b1;
            rsp_sing_in = sing_ff;
            rsp_last_in = k_ff == 4'(MATRIX_ELEMENTS - 1);
            if (sing_ff) begin
               rsp_value_in = 32'sh7FFFFFFF;
            end else if (neg_ff) begin
               rsp_value_in = (shifted > 84'h80000000) ? 32'sh80000000 : -shifted[31:0];
            end else begin
               rsp_value_in = (shifted > 84'h7FFFFFFF) ? 32'sh7FFFFFFF : shifted[31:0];
            end
            k_in = k_ff + 4'd1;
            state_in = (k_ff == 4'(MATRIX_ELEMENTS - 1)) ? ST_IDLE : ST_OUT_0;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      mat_ff <= mat_in;
      cof_ff <= cof_in;
      x_ff <= x_in;
      p1_ff <= p1_in;
      p2_ff <= p2_in;
      acc_ff <= acc_in;
      dp_ff <= dp_in;
      dsum_ff <= dsum_in;
      det_neg_ff <= det_neg_in;
      dmag_ff <= dmag_in;
      sing_ff <= sing_in;
      e_ff <= e_in;
      rem_ff <= rem_in;
      q_ff <= q_in;
      mag_ff <= mag_in;
      neg_ff <= neg_in;
      plo_ff <= plo_in;
      phi_ff <= phi_in;
      sum_ff <= sum_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sing_ff <= rsp_sing_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff <= '0;
         t_ff <= '0;
         div_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff <= k_in;
         t_ff <= t_in;
         div_cnt_ff <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_inverse_value = rsp_value_ff;
   assign rsp_singular = rsp_sing_ff;
   assign rsp_last_of_run = rsp_last_ff;

endmodule

[sv/matrix_inverse_4x4_unit.sv]
// 4x4 matrix inverse by cofactors. Feed the sixteen Q8.8 entries row-major with
// start; each transaction is taken when busy is low. Entries pass through a
// two-entry queue into the compute engine, so loading runs at one entry per cycle
// until the queue fills. After the sixteenth entry the engine, which performs its
// multiplications one per state, computes the adjugate, then the determinant, then
// normalizes the determinant magnitude and divides for the reciprocal (both skipped
// for a singular matrix), then emits the results in turn; meanwhile
// busy stays high once the queue is full. Sixteen results follow per matrix on
// rsp_valid, one cycle each; they cannot be held off, so sample every strobe.
// Singular matrices give 0x7FFFFFFF with rsp_singular set.
module matrix_inverse_4x4_unit
   import mi4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic signed [ELEM_W-1:0] req_element_value,
   output logic                     rsp_valid,
   output logic signed [OUT_W-1:0]  rsp_inverse_value,
   output logic                     rsp_singular,
   output logic                     rsp_last_of_run,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic [THR_W-1:0] threshold_ff, threshold_in;
   logic queue_full, queue_empty, push, pop;
   elem_type push_entry, pop_entry;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? threshold_ff : 32'd0;
   assign threshold_in = (psel && penable && pwrite && paddr[2] == 1'b0) ? pwdata : threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   mi4_front u_front (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .element_value (req_element_value),
      .queue_full    (queue_full),
      .busy          (busy),
      .push          (push),
      .entry         (push_entry)
   );

   mi4_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .din   (push_entry),
      .pop   (pop),
      .dout  (pop_entry),
      .full  (queue_full),
      .empty (queue_empty)
   );

   mi4_back u_back (
      .clock             (clock),
      .reset             (reset),
      .entry             (pop_entry),
      .queue_empty       (queue_empty),
      .threshold         (threshold_ff),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_inverse_value (rsp_inverse_value),
      .rsp_singular      (rsp_singular),
      .rsp_last_of_run   (rsp_last_of_run)
   );

   a_last_needs_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_last_of_run |-> rsp_valid) else $error("last flag without result");

   a_singular_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_singular) |-> (rsp_inverse_value == 32'sh7FFFFFFF))
      else $error("singular result not saturated");

   a_result_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("results too close");

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      !(queue_full && queue_empty)) else $error("queue count broken");

endmodule

[verif/mi4_checker.sv]
`timescale 1ns / 100ps

module mi4_checker
   import mi4_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic signed [ELEM_W-1:0] req_element_value,
   input  logic                     rsp_valid,
   input  logic signed [OUT_W-1:0]  rsp_inverse_value,
   input  logic                     rsp_singular,
   input  logic                     rsp_last_of_run,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [2:0]               paddr,
   input  logic [31:0]              pwdata,
   input  logic                     pready,
   output int                       fail_count,
   output int                       pending
);

   typedef struct {
      logic [OUT_W-1:0] value;
      logic             singular;
      logic             last;
   } inverse_entry_type;

   inverse_entry_type inverse_queue[$];
   longint            entries[MATRIX_ELEMENTS];
   int                fill_count;
   logic [THR_W-1:0]  threshold;

   function automatic longint minor3(input longint mtx[MATRIX_ELEMENTS],
                                     input int dr, input int dc);
      int rs[3];
      int cs[3];
      int kr;
      int kc;
      longint a[3][3];
      kr = 0;
      kc = 0;
      for (int i = 0; i < 4; i++) begin
         if (i != dr) begin
            rs[kr] = i;
            kr++;
         end
         if (i != dc) begin
            cs[kc] = i;
            kc++;
         end
      end
      for (int i = 0; i < 3; i++)
         for (int j = 0; j < 3; j++)
            a[i][j] = mtx[rs[i] * 4 + cs[j]];
      return a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
           - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
           + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
   endfunction

   task automatic predict_inverse(input longint mtx[MATRIX_ELEMENTS]);
      longint adj[MATRIX_ELEMENTS];
      longint hsum;
      longint lsum;
      longint prod;
      longint det;
      logic [63:0] dmag;
      logic [63:0] amag;
      logic [127:0] q;
      logic [127:0] w;
      int e;
      logic sing;
      logic neg;
      inverse_entry_type ent;
      hsum = 0;
      lsum = 0;
      for (int r = 0; r < 4; r++)
         for (int c = 0; c < 4; c++) begin
            adj[r * 4 + c] = ((r + c) % 2 == 1) ? -minor3(mtx, c, r) : minor3(mtx, c, r);
         end
      for (int k = 0; k < 4; k++) begin
         prod = mtx[k] * adj[k * 4];
         hsum += prod >>> 8;
         lsum += longint'(prod[7:0]);
      end
      det = hsum + (lsum >>> 8);
      dmag = det < 0 ? 64'(-det) : 64'(det);
      sing = dmag <= 64'(threshold);
      e = 0;
      q = 0;
      if (!sing) begin
         for (int i = 0; i < 64; i++)
            if (dmag[i]) e = i;
         q = (128'(1) << (e + 32)) / 128'(dmag);
      end
      for (int k = 0; k < MATRIX_ELEMENTS; k++) begin
         ent.singular = sing;
         ent.last = (k == MATRIX_ELEMENTS - 1);
         if (sing) begin
            ent.value = 32'h7FFF_FFFF;
         end else if (adj[k] == 0) begin
            ent.value = 0;
         end else begin
            neg = (adj[k] < 0) != (det < 0);
            amag = adj[k] < 0 ? 64'(-adj[k]) : 64'(adj[k]);
            w = 128'(amag) * q + (128'(1) << (e + 15));
            w = w >> (e + 16);
            if (neg) ent.value = (w > 128'h8000_0000) ? 32'h8000_0000 : -w[31:0];
            else ent.value = (w > 128'h7FFF_FFFF) ? 32'h7FFF_FFFF : w[31:0];
         end
         inverse_queue.push_back(ent);
      end
   endtask

   always @(posedge clock) begin
      inverse_entry_type exp_ent;
      if (reset) begin
         inverse_queue.delete();
         fill_count = 0;
         threshold = THRESHOLD_RESET;
         fail_count = 0;
      end else begin
         if (rsp_valid) begin
            if (inverse_queue.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result value=%h singular=%b last=%b",
                           rsp_inverse_value, rsp_singular, rsp_last_of_run);
            end else begin
               exp_ent = inverse_queue.pop_front();
               if (rsp_inverse_value !== exp_ent.value || rsp_singular !== exp_ent.singular ||
                   rsp_last_of_run !== exp_ent.last) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("mismatch exp value=%h singular=%b last=%b got %h %b %b",
                              exp_ent.value, exp_ent.singular, exp_ent.last,
                              rsp_inverse_value, rsp_singular, rsp_last_of_run);
               end
            end
         end
         if (psel && penable && pwrite && pready && paddr[2] == 1'b0)
            threshold = pwdata;
         if (start && !busy) begin
            entries[fill_count] = longint'(req_element_value);
            if (fill_count == MATRIX_ELEMENTS - 1) begin
               fill_count = 0;
               predict_inverse(entries);
            end else begin
               fill_count++;
            end
         end
      end
      pending = inverse_queue.size();
   end

endmodule

[verif/testbench.sv]
`timescale 1ns / 100ps

module testbench;
   import mi4_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic signed [ELEM_W-1:0] req_element_value = '0;
   logic                     rsp_valid;
   logic signed [OUT_W-1:0]  rsp_inverse_value;
   logic                     rsp_singular;
   logic                     rsp_last_of_run;
   logic                     psel = 1'b0;
   logic                     penable = 1'b0;
   logic                     pwrite = 1'b0;
   logic [2:0]               paddr = '0;
   logic [31:0]              pwdata = '0;
   logic [31:0]              prdata;
   logic                     pready;
   int                       fail_count;
   int                       pending;
   int                       quiet_cycles = 0;
   bit                       idle_enable = 1'b1;

   localparam int QUIET_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 700;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   matrix_inverse_4x4_unit i_dut (.*);

   mi4_checker i_checker (.*);

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || psel) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_entry(input logic [15:0] v);
      bit taken;
      while (idle_enable && $urandom_range(99) < 15) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_element_value <= v;
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] make_entry(input int kind, input int idx);
      logic [15:0] picks[5];
      picks = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0100, 16'hFF00};
      case (kind)
         0: return 16'($urandom);
         1: return (idx % 5 == 0) ? 16'($urandom_range(2048, 512))
                                   : 16'($signed($urandom_range(512)) - 256);
         2: return picks[$urandom_range(4)];
         3: return (idx % 5 == 0) ? 16'($urandom_range(4096, 1)) : 16'h0000;
         default: return 16'h0000;
      endcase
   endfunction

   task automatic send_matrix(input int kind);
      for (int i = 0; i < MATRIX_ELEMENTS; i++) send_entry(make_entry(kind, i));
   endtask

   initial begin
      logic [31:0] thresholds[5];
      logic [15:0] near_singular[16];
      thresholds = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000, 32'd168};
      near_singular = '{16'h7FFF, 16'h7FFE, 16'h0000, 16'h0000,
                        16'h7FFE, 16'h7FFD, 16'h0000, 16'h0000,
                        16'h0000, 16'h0000, 16'h0100, 16'h0000,
                        16'h0000, 16'h0000, 16'h0000, 16'h0100};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // saturating inverse of both signs with the reset threshold
      for (int i = 0; i < 16; i++) send_entry(near_singular[i]);
      send_matrix(4);
      write_csr(3'd4, 32'd0);
      for (int p = 0; p < 5; p++) begin
         write_csr(3'd0, (p == 3) ? $urandom : thresholds[p]);
         idle_enable = (p != 2);
         send_matrix(3);
         if (p % 2 == 0) send_matrix(2);
         send_matrix($urandom_range(99) < 60 ? 0 : 1);
      end
      for (int i = 0; i < 5; i++) send_entry(16'($urandom));
      start <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

[sim.f]
sv/mi4_pkg.sv
sv/mi4_fifo.sv
sv/mi4_front.sv
sv/mi4_back.sv
sv/matrix_inverse_4x4_unit.sv
verif/mi4_checker.sv
verif/testbench.sv
